// ===== src/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit bitmap block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  // default sizes of the allocator
  localparam int unsigned MAP_BITS_DEF    = 1024;
  localparam int unsigned MAX_RUN_DEF     = 12;
  localparam int unsigned BLOCK_SHIFT_DEF = 12;

  // map words held in the ram
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WORD_LSB = 5;
  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned SUB_W    = 2;

  // configuration port
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned RB_W    = 11;
  localparam logic [RB_W-1:0] REGION_BLOCKS_RST = 11'd1024;

  localparam logic [0:0] REG_REGION_START  = 1'b0;
  localparam logic [0:0] REG_REGION_BLOCKS = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC     = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_ASCAN,
    S_MMOD,
    S_RC_INIT,
    S_RC_CNT
  } state_e;

  // what the word unit reports on the current map word
  typedef struct packed {
    logic                any_free;
    logic [WORD_LSB-1:0] first;
    logic [3:0]          chunk_free;
  } word_info_t;

endpackage

// ===== src/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned WIDTH = ffba_pkg::WORD_W,
  parameter int unsigned DEPTH = ffba_pkg::MAP_BITS_DEF / ffba_pkg::WORD_W
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ffba_word_unit.sv =====
// ----------------------------------------------------------------------------
// ffba_word_unit
// Free-bit unit on one map word: region mask, lowest free bit and the free
// count of one byte of the word.
// ----------------------------------------------------------------------------
module ffba_word_unit #(
  parameter int unsigned WA_W  = 5,
  parameter int unsigned EXT_W = 12
) (
  input  logic [ffba_pkg::WORD_W-1:0] word_i,
  input  logic [WA_W-1:0]             word_addr_i,
  input  logic [EXT_W-1:0]            n_i,
  input  logic [ffba_pkg::SUB_W-1:0]  sub_i,
  output ffba_pkg::word_info_t        info_o
);

  logic [EXT_W-1:0]              base;
  logic [EXT_W-1:0]              rem;
  logic [ffba_pkg::WORD_W-1:0]   mask;
  logic [ffba_pkg::WORD_W-1:0]   free_bits;
  logic [ffba_pkg::CHUNK_W-1:0]  chunk;
  logic [ffba_pkg::WORD_LSB-1:0] first;
  logic [3:0]                    cnt;

  assign base = EXT_W'({word_addr_i, {ffba_pkg::WORD_LSB{1'b0}}});
  assign rem  = n_i - base;

  // only bits below the region size take part
  always_comb begin
    if (n_i <= base) begin
      mask = '0;
    end else if (rem >= EXT_W'(ffba_pkg::WORD_W)) begin
      mask = '1;
    end else begin
      mask = ~({ffba_pkg::WORD_W{1'b1}} << rem[ffba_pkg::WORD_LSB-1:0]);
    end
  end

  assign free_bits = ~word_i & mask;
  assign chunk     = free_bits[{sub_i, 3'b000} +: ffba_pkg::CHUNK_W];

  always_comb begin
    first = '0;
    for (int i = ffba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        first = ffba_pkg::WORD_LSB'(i);
      end
    end
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < ffba_pkg::CHUNK_W; i++) begin
      cnt = cnt + 4'(chunk[i]);
    end
  end

  assign info_o.any_free   = |free_bits;
  assign info_o.first      = first;
  assign info_o.chunk_free = cnt;

endmodule

// ===== src/first_fit_bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_bitmap_block_allocator
// Bitmap block allocator: first-fit runs, single-bit mark used and mark free.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i, file_size_i and block_index_i and raise start; the
// command is taken at a clock edge with start high and busy low. Results
// come out one per cycle, save where an allocate steps past a full word,
// with out_valid_o high for exactly one cycle each; last_o marks the final
// one of a command. The receiver cannot stall, so every strobed transfer is
// taken as it stands. An allocate gives one result per claimed block, or one
// status result. The map is kept as 32-bit words in a ram and walked by one
// free-bit unit: an allocate claims the lowest free bit of the current word
// per result, writes back each word it leaves full and the word of its last
// claim; a mark command reads, modifies and writes back one word. Reset
// starts a clearing pass over every map word, with busy high. A write of
// region_blocks through the APB port starts a recount of the free blocks,
// one byte of a map word at a time, with busy high. region_start writes take
// effect at once.
// ----------------------------------------------------------------------------
module first_fit_bitmap_block_allocator #(
  parameter int unsigned MAP_BITS    = ffba_pkg::MAP_BITS_DEF,
  parameter int unsigned MAX_RUN     = ffba_pkg::MAX_RUN_DEF,
  parameter int unsigned BLOCK_SHIFT = ffba_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   cmd_i,
  input  logic [31:0]                  file_size_i,
  input  logic [9:0]                   block_index_i,
  output logic                         out_valid_o,
  output logic [1:0]                   status_o,
  output logic [31:0]                  block_number_o,
  output logic [3:0]                   run_position_o,
  output logic [3:0]                   run_length_o,
  output logic                         last_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0] paddr,
  input  logic [ffba_pkg::DATA_W-1:0]  pwdata,
  output logic [ffba_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned WORDS = (MAP_BITS + ffba_pkg::WORD_W - 1) / ffba_pkg::WORD_W;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned GI_W  = WA_W + ffba_pkg::WORD_LSB;
  localparam int unsigned CNT_W = $clog2(MAP_BITS + 1);
  localparam int unsigned EXT_W = ((CNT_W > ffba_pkg::RB_W) ? CNT_W : ffba_pkg::RB_W) + 1;
  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);
  localparam int unsigned RST_FREE =
    (int'(ffba_pkg::REGION_BLOCKS_RST) > MAP_BITS) ? MAP_BITS
                                                   : int'(ffba_pkg::REGION_BLOCKS_RST);
  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  ffba_pkg::state_e state_q, state_d;
  logic                        pend_q, pend_d;
  logic [WA_W-1:0]             addr_q, addr_d;
  logic [ffba_pkg::WORD_W-1:0] word_q, word_d;
  logic                        fresh_q, fresh_d;
  logic [ffba_pkg::SUB_W-1:0]  sub_q, sub_d;
  logic [RUN_W-1:0]            k_q, k_d;
  logic [RUN_W-1:0]            need_q, need_d;
  logic [CNT_W-1:0]            free_q, free_d;
  ffba_pkg::cmd_e              cmd_q;
  logic [31:0]                 size_q;
  logic [9:0]                  idx_q;
  logic [31:0]                 region_start_q;
  logic [ffba_pkg::RB_W-1:0]   region_blocks_q;

  logic                        out_valid_q, out_valid_d;
  ffba_pkg::status_e           status_q, status_d;
  logic [31:0]                 bnum_q, bnum_d;
  logic [3:0]                  pos_q, pos_d;
  logic [3:0]                  len_q, len_d;
  logic                        last_q, last_d;

  logic                        ram_we;
  logic [WA_W-1:0]             ram_waddr;
  logic [ffba_pkg::WORD_W-1:0] ram_wdata;
  logic [WA_W-1:0]             ram_raddr;
  logic [ffba_pkg::WORD_W-1:0] ram_rdata;

  logic                        accept;
  logic                        cfg_wr;
  logic                        rb_wr;
  logic [EXT_W-1:0]            rb_ext;
  logic [EXT_W-1:0]            n_eff;
  logic [32:0]                 size_sum;
  logic [32:0]                 need_full;
  logic                        too_large;
  logic                        need_zero;
  logic [RUN_W-1:0]            need_short;
  logic                        short_free;
  logic                        idx_ok;
  logic [GI_W-1:0]             idx_g;
  logic [ffba_pkg::WORD_W-1:0] cur;
  logic [ffba_pkg::WORD_W-1:0] claim_bit;
  logic [ffba_pkg::WORD_W-1:0] mark_bit;
  logic [31:0]                 bnum_claim;
  logic                        claim_last;
  ffba_pkg::word_info_t        info;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign rb_wr  = cfg_wr && (paddr[ffba_pkg::PADDR_W-1] == ffba_pkg::REG_REGION_BLOCKS);
  assign prdata = (paddr[ffba_pkg::PADDR_W-1] == ffba_pkg::REG_REGION_BLOCKS)
                  ? ffba_pkg::DATA_W'(region_blocks_q) : region_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q  <= '0;
      region_blocks_q <= ffba_pkg::REGION_BLOCKS_RST;
    end else if (cfg_wr) begin
      if (paddr[ffba_pkg::PADDR_W-1] == ffba_pkg::REG_REGION_BLOCKS) begin
        region_blocks_q <= pwdata[ffba_pkg::RB_W-1:0];
      end else begin
        region_start_q <= pwdata;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // shared decode terms
  // ---------------------------------------------------------------------------
  assign busy   = (state_q != ffba_pkg::S_IDLE) | pend_q;
  assign accept = start & ~busy;

  assign rb_ext = EXT_W'(region_blocks_q);
  assign n_eff  = (rb_ext > EXT_W'(MAP_BITS)) ? EXT_W'(MAP_BITS) : rb_ext;

  assign size_sum   = {1'b0, size_q} + ((33'd1 << BLOCK_SHIFT) - 33'd1);
  assign need_full  = size_sum >> BLOCK_SHIFT;
  assign too_large  = need_full > 33'(MAX_RUN);
  assign need_zero  = (need_full == 33'd0);
  assign need_short = RUN_W'(need_full);
  assign short_free = EXT_W'(free_q) < EXT_W'(need_short);

  assign idx_ok = EXT_W'(idx_q) < n_eff;
  assign idx_g  = GI_W'(idx_q);

  // the word just read is used once, then the working copy
  assign cur        = fresh_q ? ram_rdata : word_q;
  assign claim_bit  = ffba_pkg::WORD_W'(1) << info.first;
  assign mark_bit   = ffba_pkg::WORD_W'(1) << idx_g[ffba_pkg::WORD_LSB-1:0];
  assign bnum_claim = region_start_q + 32'({addr_q, info.first});
  assign claim_last = (RUN_W'(k_q + 1'b1) == need_q);

  ffba_word_unit #(
    .WA_W  (WA_W),
    .EXT_W (EXT_W)
  ) u_word_unit (
    .word_i      (cur),
    .word_addr_i (addr_q),
    .n_i         (n_eff),
    .sub_i       (sub_q),
    .info_o      (info)
  );

  ffba_ram #(
    .WIDTH (ffba_pkg::WORD_W),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffba_pkg::S_CLEAR: begin
        if (addr_q == LAST_WORD) begin
          state_d = pend_q ? ffba_pkg::S_RC_INIT : ffba_pkg::S_IDLE;
        end
      end
      ffba_pkg::S_IDLE: begin
        if (pend_q) begin
          state_d = ffba_pkg::S_RC_INIT;
        end else if (accept) begin
          state_d = ffba_pkg::S_DECODE;
        end
      end
      ffba_pkg::S_DECODE: begin
        case (cmd_q)
          ffba_pkg::CMD_ALLOC: begin
            if (too_large || need_zero || short_free) begin
              state_d = ffba_pkg::S_IDLE;
            end else begin
              state_d = ffba_pkg::S_ASCAN;
            end
          end
          ffba_pkg::CMD_MARK_USED, ffba_pkg::CMD_MARK_FREE: begin
            state_d = idx_ok ? ffba_pkg::S_MMOD : ffba_pkg::S_IDLE;
          end
          default: state_d = ffba_pkg::S_IDLE;
        endcase
      end
      ffba_pkg::S_ASCAN: begin
        if (info.any_free && claim_last) begin
          state_d = ffba_pkg::S_IDLE;
        end
      end
      ffba_pkg::S_MMOD:    state_d = ffba_pkg::S_IDLE;
      ffba_pkg::S_RC_INIT: state_d = ffba_pkg::S_RC_CNT;
      ffba_pkg::S_RC_CNT: begin
        if (rb_wr) begin
          state_d = ffba_pkg::S_RC_INIT;
        end else if ((sub_q == '1) && (addr_q == LAST_WORD)) begin
          state_d = ffba_pkg::S_IDLE;
        end
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: datapath and outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    pend_d      = pend_q | rb_wr;
    addr_d      = addr_q;
    word_d      = word_q;
    fresh_d     = fresh_q;
    sub_d       = sub_q;
    k_d         = k_q;
    need_d      = need_q;
    free_d      = free_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    bnum_d      = bnum_q;
    pos_d       = pos_q;
    len_d       = len_q;
    last_d      = last_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = cur;
    ram_raddr   = addr_q;

    case (state_q)
      ffba_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        addr_d    = WA_W'(addr_q + 1'b1);
      end
      ffba_pkg::S_IDLE: begin
        fresh_d = 1'b0;
      end
      ffba_pkg::S_DECODE: begin
        case (cmd_q)
          ffba_pkg::CMD_ALLOC: begin
            if (too_large || need_zero || short_free) begin
              out_valid_d = 1'b1;
              bnum_d      = '0;
              pos_d       = '0;
              len_d       = '0;
              last_d      = 1'b1;
              if (too_large) begin
                status_d = ffba_pkg::ST_TOO_LARGE;
              end else if (need_zero) begin
                status_d = ffba_pkg::ST_OK;
              end else begin
                status_d = ffba_pkg::ST_NO_SPACE;
              end
            end else begin
              need_d    = need_short;
              k_d       = '0;
              addr_d    = '0;
              ram_raddr = '0;
              fresh_d   = 1'b1;
            end
          end
          ffba_pkg::CMD_MARK_USED, ffba_pkg::CMD_MARK_FREE: begin
            if (!idx_ok) begin
              out_valid_d = 1'b1;
              status_d    = ffba_pkg::ST_RANGE;
              bnum_d      = '0;
              pos_d       = '0;
              len_d       = '0;
              last_d      = 1'b1;
            end else begin
              addr_d    = idx_g[GI_W-1:ffba_pkg::WORD_LSB];
              ram_raddr = idx_g[GI_W-1:ffba_pkg::WORD_LSB];
              fresh_d   = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ffba_pkg::S_ASCAN: begin
        fresh_d = 1'b0;
        if (info.any_free) begin
          word_d      = cur | claim_bit;
          out_valid_d = 1'b1;
          status_d    = ffba_pkg::ST_OK;
          bnum_d      = bnum_claim;
          pos_d       = 4'(k_q);
          len_d       = 4'(need_q);
          last_d      = claim_last;
          k_d         = RUN_W'(k_q + 1'b1);
          free_d      = CNT_W'(free_q - 1'b1);
          if (claim_last) begin
            ram_we    = 1'b1;
            ram_wdata = cur | claim_bit;
          end
        end else begin
          // word exhausted: write it back and move on
          ram_we    = 1'b1;
          ram_wdata = cur;
          addr_d    = WA_W'(addr_q + 1'b1);
          ram_raddr = WA_W'(addr_q + 1'b1);
          fresh_d   = 1'b1;
        end
      end
      ffba_pkg::S_MMOD: begin
        fresh_d     = 1'b0;
        ram_we      = 1'b1;
        out_valid_d = 1'b1;
        status_d    = ffba_pkg::ST_OK;
        bnum_d      = region_start_q + 32'(idx_g);
        pos_d       = '0;
        len_d       = '0;
        last_d      = 1'b1;
        if (cmd_q == ffba_pkg::CMD_MARK_USED) begin
          ram_wdata = cur | mark_bit;
          if ((cur & mark_bit) == '0) begin
            free_d = CNT_W'(free_q - 1'b1);
          end
        end else begin
          ram_wdata = cur & ~mark_bit;
          if ((cur & mark_bit) != '0) begin
            free_d = CNT_W'(free_q + 1'b1);
          end
        end
      end
      ffba_pkg::S_RC_INIT: begin
        pend_d    = rb_wr;
        addr_d    = '0;
        sub_d     = '0;
        free_d    = '0;
        ram_raddr = '0;
        fresh_d   = 1'b1;
      end
      ffba_pkg::S_RC_CNT: begin
        if (!rb_wr) begin
          free_d  = CNT_W'(free_q + CNT_W'(info.chunk_free));
          word_d  = cur;
          fresh_d = 1'b0;
          sub_d   = ffba_pkg::SUB_W'(sub_q + 1'b1);
          if ((sub_q == '1) && (addr_q != LAST_WORD)) begin
            addr_d    = WA_W'(addr_q + 1'b1);
            ram_raddr = WA_W'(addr_q + 1'b1);
            fresh_d   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffba_pkg::S_CLEAR;
      pend_q      <= 1'b0;
      addr_q      <= '0;
      fresh_q     <= 1'b0;
      sub_q       <= '0;
      k_q         <= '0;
      free_q      <= CNT_W'(RST_FREE);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      addr_q      <= addr_d;
      fresh_q     <= fresh_d;
      sub_q       <= sub_d;
      k_q         <= k_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q   <= word_d;
    need_q   <= need_d;
    status_q <= status_d;
    bnum_q   <= bnum_d;
    pos_q    <= pos_d;
    len_q    <= len_d;
    last_q   <= last_d;
    if (accept) begin
      cmd_q  <= ffba_pkg::cmd_e'(cmd_i);
      size_q <= file_size_i;
      idx_q  <= block_index_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign block_number_o = bnum_q;
  assign run_position_o = pos_q;
  assign run_length_o   = len_q;
  assign last_o         = last_q;

endmodule
